>>> rtl/core/fdm_pkg.sv
// Shared types and constants for the floored divide/modulo pipeline.
package fdm_pkg;

    localparam int FDM_W     = 64;
    localparam int FDM_HW    = 32;
    localparam int FDM_STEPS = FDM_W;

    localparam logic REQ_QUOT = 1'b0;
    localparam logic REQ_MOD  = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [FDM_W-1:0] rem;
        logic [FDM_W-1:0] nq;
        logic [FDM_W-1:0] ay;
        logic             nx;
        logic             ny;
        logic             want_mod;
        logic             wide;
        logic             zero;
    } fdm_stage_t;

    typedef struct packed {
        logic             valid;
        logic [FDM_W-1:0] q;
        logic [FDM_W-1:0] r;
        logic [FDM_W-1:0] d;
        logic             nz;
        logic             nx;
        logic             ny;
        logic             want_mod;
        logic             wide;
        logic             zero;
    } fdm_fix_t;

endpackage

>>> rtl/core/fdm_pre.sv
// Input stage: width select, sign extraction, magnitudes, zero divisor detect.
module fdm_pre (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic                            req_type,
    input  logic                            long_op,
    input  logic [fdm_pkg::FDM_W-1:0]       dividend,
    input  logic [fdm_pkg::FDM_W-1:0]       divisor,
    output fdm_pkg::fdm_stage_t             stage_out
);
    import fdm_pkg::*;

    logic [FDM_W-1:0] x;
    logic [FDM_W-1:0] y;
    fdm_stage_t       stage_reg;
    fdm_stage_t       stage_next;

    always_comb
    begin
        if (long_op)
        begin
            x = dividend;
            y = divisor;
        end
        else
        begin
            x = {{(FDM_W-FDM_HW){dividend[FDM_HW-1]}}, dividend[FDM_HW-1:0]};
            y = {{(FDM_W-FDM_HW){divisor[FDM_HW-1]}}, divisor[FDM_HW-1:0]};
        end
        stage_next.valid    = in_valid;
        stage_next.rem      = '0;
        stage_next.nx       = x[FDM_W-1];
        stage_next.ny       = y[FDM_W-1];
        stage_next.nq       = x[FDM_W-1] ? (FDM_W'(0) - x) : x;
        stage_next.ay       = y[FDM_W-1] ? (FDM_W'(0) - y) : y;
        stage_next.want_mod = (req_type == REQ_MOD);
        stage_next.wide     = long_op;
        stage_next.zero     = (y == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

>>> rtl/core/fdm_div_stage.sv
// One restoring division step: one quotient bit per register stage.
module fdm_div_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  fdm_pkg::fdm_stage_t stage_in,
    output fdm_pkg::fdm_stage_t stage_out
);
    import fdm_pkg::*;

    logic [FDM_W:0] trial;
    logic           ge;
    fdm_stage_t     stage_reg;
    fdm_stage_t     stage_next;

    always_comb
    begin
        trial      = {stage_in.rem, stage_in.nq[FDM_W-1]} - {1'b0, stage_in.ay};
        ge         = !trial[FDM_W];
        stage_next = stage_in;
        stage_next.rem = ge ? trial[FDM_W-1:0] : {stage_in.rem[FDM_W-2:0],
                                                  stage_in.nq[FDM_W-1]};
        stage_next.nq  = {stage_in.nq[FDM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

>>> rtl/core/fdm_post.sv
// Output stages: floor correction, result select, zero-divisor clearing, short-mode sign extension.
module fdm_post (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  fdm_pkg::fdm_stage_t        stage_in,
    output logic                       out_valid,
    output logic [fdm_pkg::FDM_W-1:0]  result_value,
    output logic                       div_by_zero
);
    import fdm_pkg::*;

    fdm_fix_t         fix_reg;
    fdm_fix_t         fix_next;
    logic             diff;
    logic [FDM_W-1:0] qf;
    logic [FDM_W-1:0] rf;
    logic [FDM_W-1:0] res;
    logic             valid_reg;
    logic [FDM_W-1:0] result_reg;
    logic [FDM_W-1:0] result_next;
    logic             zero_reg;

    always_comb
    begin
        fix_next.valid    = stage_in.valid;
        fix_next.q        = stage_in.nq;
        fix_next.r        = stage_in.rem;
        fix_next.d        = stage_in.ay - stage_in.rem;
        fix_next.nz       = (stage_in.rem != '0);
        fix_next.nx       = stage_in.nx;
        fix_next.ny       = stage_in.ny;
        fix_next.want_mod = stage_in.want_mod;
        fix_next.wide     = stage_in.wide;
        fix_next.zero     = stage_in.zero;
    end

    always_comb
    begin
        diff = fix_reg.nx ^ fix_reg.ny;
        if (diff)
        begin
            qf = fix_reg.nz ? ~fix_reg.q : (FDM_W'(0) - fix_reg.q);
        end
        else
        begin
            qf = fix_reg.q;
        end
        if (diff && fix_reg.nz)
        begin
            rf = fix_reg.ny ? (FDM_W'(0) - fix_reg.d) : fix_reg.d;
        end
        else
        begin
            rf = fix_reg.nx ? (FDM_W'(0) - fix_reg.r) : fix_reg.r;
        end
        res = fix_reg.want_mod ? rf : qf;
        if (fix_reg.zero)
        begin
            result_next = '0;
        end
        else if (fix_reg.wide)
        begin
            result_next = res;
        end
        else
        begin
            result_next = {{(FDM_W-FDM_HW){res[FDM_HW-1]}}, res[FDM_HW-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_reg    <= '0;
            valid_reg  <= 1'b0;
            result_reg <= '0;
            zero_reg   <= 1'b0;
        end
        else if (en)
        begin
            fix_reg    <= fix_next;
            valid_reg  <= fix_reg.valid;
            result_reg <= result_next;
            zero_reg   <= fix_reg.zero;
        end
    end

    assign out_valid    = valid_reg;
    assign result_value = result_reg;
    assign div_by_zero  = zero_reg;

endmodule

>>> rtl/core/floored_div_mod_unit.sv
// Top level of the pipelined floored signed divide/modulo unit.
// Accepts one transaction per cycle unless m_tready holds the output; each
// result passes through one input stage, 64 one-bit restoring division
// stages and two correction/output stages. The whole pipeline advances together
// whenever the output register is empty or being taken, so s_tready follows
// m_tready combinationally. A zero divisor returns 0 with div_by_zero set; in
// 32-bit mode only the low halves of the operands are used and the result is
// sign-extended.
module floored_div_mod_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [2*fdm_pkg::FDM_W-1:0]  s_tdata,   // dividend, divisor
    input  logic [1:0]                   s_tuser,   // req_type, long_op
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [fdm_pkg::FDM_W-1:0]    m_tdata,   // result_value
    output logic                         m_tuser    // div_by_zero
);
    import fdm_pkg::*;

    logic       en;
    fdm_stage_t stage [FDM_STEPS+1];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    fdm_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .req_type  (s_tuser[0]),
        .long_op   (s_tuser[1]),
        .dividend  (s_tdata[FDM_W-1:0]),
        .divisor   (s_tdata[2*FDM_W-1:FDM_W]),
        .stage_out (stage[0])
    );

    for (genvar i = 0; i < FDM_STEPS; i++)
    begin : g_step
        fdm_div_stage u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_in  (stage[i]),
            .stage_out (stage[i+1])
        );
    end

    fdm_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .stage_in     (stage[FDM_STEPS]),
        .out_valid    (m_tvalid),
        .result_value (m_tdata),
        .div_by_zero  (m_tuser)
    );

endmodule

>>> test/floored_div_mod_unit_test.sv
// Self-checking testbench for the floored divide/modulo unit: directed and random operands.
`timescale 1ns / 100ps

module floored_div_mod_unit_test;

    localparam logic WIDTH_32 = 1'b0;
    localparam logic WIDTH_64 = 1'b1;

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG1  = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic        req_type;
        logic        long_op;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic [63:0] value;
        logic        dbz;
    } div_res_t;

    class DivScoreboard;
        div_res_t expected_q[$];
        int       mismatches;
        int       n_noted;

        function new();
            mismatches = 0;
            n_noted    = 0;
        endfunction

        static function logic [63:0] sext32(logic [63:0] v);
            return {{32{v[31]}}, v[31:0]};
        endfunction

        static function div_res_t floor_divmod(div_req_t rq);
            logic [63:0] x, y, ax, ay, q, r;
            logic        nx, ny;
            div_res_t    res;
            x = rq.dividend;
            y = rq.divisor;
            if (rq.long_op == WIDTH_32)
            begin
                x = sext32(x);
                y = sext32(y);
            end
            if (y == 64'd0)
            begin
                res.value = 64'd0;
                res.dbz   = 1'b1;
                return res;
            end
            nx = x[63];
            ny = y[63];
            ax = nx ? (64'd0 - x) : x;
            ay = ny ? (64'd0 - y) : y;
            q  = ax / ay;
            r  = ax % ay;
            if (nx != ny)
                q = 64'd0 - q;
            if (nx)
                r = 64'd0 - r;
            // round toward minus infinity when signs differ and division is inexact
            if (r != 64'd0 && nx != ny)
            begin
                q = q - 64'd1;
                r = r + y;
            end
            res.value = (rq.req_type == fdm_pkg::REQ_MOD) ? r : q;
            if (rq.long_op == WIDTH_32)
                res.value = sext32(res.value);
            res.dbz = 1'b0;
            return res;
        endfunction

        function void note_request(div_req_t rq);
            expected_q.push_back(floor_divmod(rq));
            n_noted++;
        endfunction

        function void check_result(logic [63:0] value, logic dbz);
            div_res_t exp_r;
            if (expected_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: value=%h div_by_zero=%b", value, dbz);
                mismatches++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (value !== exp_r.value || dbz !== exp_r.dbz)
            begin
                if (mismatches < 10)
                    $display({"mismatch: expected value=%h div_by_zero=%b, ",
                              "got value=%h div_by_zero=%b"},
                             exp_r.value, exp_r.dbz, value, dbz);
                mismatches++;
            end
        endfunction
    endclass

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;

    DivScoreboard sb = new();

    floored_div_mod_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // dividend, divisor
        .s_tuser  (s_tuser),    // req_type, long_op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // result_value
        .m_tuser  (m_tuser)     // div_by_zero
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        int          sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0, 1, 2, 3: v = {$urandom(), $urandom()};
            4, 5:
            begin
                v = 64'($urandom_range(0, 32));
                if ($urandom_range(0, 1) == 1)
                    v = 64'd0 - v;
                if ($urandom_range(0, 3) == 0)
                    v[63:32] = $urandom();
            end
            6:
            begin
                v = {$urandom(), $urandom()} >> $urandom_range(0, 63);
                if ($urandom_range(0, 1) == 1)
                    v = 64'd0 - v;
            end
            default:
            begin
                case ($urandom_range(0, 8))
                    0: v = 64'd0;
                    1: v = 64'd1;
                    2: v = NEG1;
                    3: v = MIN64;
                    4: v = MAX64;
                    5: v = 64'hFFFF_FFFF_8000_0000;
                    6: v = 64'h0000_0000_7FFF_FFFF;
                    7: v = 64'hFFFF_FFFF_0000_0000;
                    default: v = 64'h0000_0000_8000_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic div_req_t make_req(logic rt, logic lo, logic [63:0] x, logic [63:0] y);
        div_req_t rq;
        rq.req_type = rt;
        rq.long_op  = lo;
        rq.dividend = x;
        rq.divisor  = y;
        return rq;
    endfunction

    task automatic send_request(div_req_t rq, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rq.divisor, rq.dividend};
        s_tuser  <= {rq.long_op, rq.req_type};
        do @(posedge clk); while (!s_tready);
        sb.note_request(rq);
    endtask

    // result side: random stalls, one long hold-off once the pipeline has work
    initial
    begin
        int stall_left;
        int cycle;
        bit held;
        stall_left = 0;
        cycle      = 0;
        held       = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (!held && sb.n_noted >= 200)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ((cycle / 500) % 4 != 0 && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        div_req_t rq;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_64, 64'd7, 64'd2), 0);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_64, 64'd7, 64'd2), 0);
        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_64, -64'sd7, 64'd2), 1);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_64, -64'sd7, 64'd2), 0);
        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_64, 64'd7, -64'sd2), 2);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_64, 64'd7, -64'sd2), 0);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_64, -64'sd7, -64'sd2), 0);
        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_64, -64'sd6, 64'd3), 0);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_64, 64'd6, -64'sd3), 3);
        // most negative over minus one
        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_64, MIN64, NEG1), 0);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_64, MIN64, NEG1), 0);
        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_32,
                              64'hFFFF_FFFF_8000_0000, 64'h1234_5678_FFFF_FFFF), 0);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_32,
                              64'h0000_0000_8000_0000, 64'hFFFF_FFFF_FFFF_FFFF), 0);
        // zero divisor; short mode looks only at the low half
        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_64, 64'd12345, 64'd0), 0);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_32, 64'd99, 64'hFFFF_0000_0000_0000), 0);
        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_64, MAX64, 64'h0000_0001_0000_0000), 0);
        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_64, MAX64, MAX64), 0);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_64, MIN64, MAX64), 0);
        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_64, MIN64, MIN64), 0);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_64, 64'd1, MIN64), 0);
        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_32,
                              64'hDEAD_BEEF_7FFF_FFFF, 64'h5555_AAAA_8000_0000), 0);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_32,
                              64'hABCD_0000_0000_0005, 64'hFFFF_FFFF_FFFF_FFFD), 0);
        send_request(make_req(fdm_pkg::REQ_QUOT, WIDTH_64, 64'd0, -64'sd5), 0);
        send_request(make_req(fdm_pkg::REQ_MOD,  WIDTH_64, MAX64, MIN64), 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            rq.req_type = 1'($urandom_range(0, 1));
            rq.long_op  = 1'($urandom_range(0, 1));
            rq.dividend = rand_operand();
            rq.divisor  = rand_operand();
            send_request(rq, (i % 100 < 20) ? 0 : pick_gap());
        end
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("PASS floored_div_mod_unit");
        else
            $display("FAIL floored_div_mod_unit");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL floored_div_mod_unit");
        $finish;
    end

endmodule

>>> floored_div_mod_unit.f
rtl/core/fdm_pkg.sv
rtl/core/fdm_pre.sv
rtl/core/fdm_div_stage.sv
rtl/core/fdm_post.sv
rtl/core/floored_div_mod_unit.sv
test/floored_div_mod_unit_test.sv
